>>> rtl/iwfe_pkg.sv
`default_nettype none
package iwfe_pkg;

  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 4;
  localparam int FEAT_W   = 32;

  localparam logic [IDX_W-1:0] F_A_MAX    = 4'd0;
  localparam logic [IDX_W-1:0] F_A_MIN    = 4'd1;
  localparam logic [IDX_W-1:0] F_A_MEAN   = 4'd2;
  localparam logic [IDX_W-1:0] F_A_STD    = 4'd3;
  localparam logic [IDX_W-1:0] F_A_P2P    = 4'd4;
  localparam logic [IDX_W-1:0] F_G_MAX    = 4'd5;
  localparam logic [IDX_W-1:0] F_G_MEAN   = 4'd6;
  localparam logic [IDX_W-1:0] F_G_STD    = 4'd7;
  localparam logic [IDX_W-1:0] F_AX_STD   = 4'd8;
  localparam logic [IDX_W-1:0] F_RZ_STD   = 4'd13;
  localparam logic [IDX_W-1:0] F_A_ENERGY = 4'd14;
  localparam logic [IDX_W-1:0] F_G_ENERGY = 4'd15;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_READ   = 17'h00002,
    S_AXIS   = 17'h00004,
    S_MUL    = 17'h00008,
    S_AXACC  = 17'h00010,
    S_SQRT   = 17'h00020,
    S_MAGSQ  = 17'h00040,
    S_MAGACC = 17'h00080,
    S_FEAT   = 17'h00100,
    S_STDB   = 17'h00200,
    S_STDC   = 17'h00400,
    S_DIV    = 17'h00800,
    S_DVDONE = 17'h01000,
    S_STDSQ  = 17'h02000,
    S_SQDONE = 17'h04000,
    S_EMIT   = 17'h08000,
    S_WAIT   = 17'h10000
  } state_t;

endpackage
`default_nettype wire

>>> rtl/iwfe_if.sv
`default_nettype none
interface iwfe_sample_if import iwfe_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t accel_x;
  sample_t accel_y;
  sample_t accel_z;
  sample_t rate_x;
  sample_t rate_y;
  sample_t rate_z;

  modport source(output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                 input ready);
  modport sink(input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
               output ready);
endinterface

interface iwfe_feature_if import iwfe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  feature_index;
  logic [FEAT_W-1:0] feature_value;
  logic              last_feature;

  modport source(output valid, feature_index, feature_value, last_feature, input ready);
  modport sink(input valid, feature_index, feature_value, last_feature, output ready);
endinterface
`default_nettype wire

>>> rtl/imu_window_feature_extractor_core.sv
`default_nettype none
// Six-axis IMU window statistics. Each accepted item is one sample written into a
// WINDOW-deep ring memory. When a sample completes a full window with at least WINDOW/2
// new samples since the last evaluation, the block walks the window, one sample at a
// time, through a shared bit-serial multiplier (M = 17+clog2(WINDOW) bit operand) and a
// shared bit-pair square root (M-bit root). It then emits 16 feature items in index
// order, each through a restoring divider (2*M-bit quotient) and square root as needed;
// last_feature marks index 15. No new sample is taken until the last feature has been
// delivered.
module imu_window_feature_extractor_core import iwfe_pkg::*; #(
  parameter int WINDOW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  iwfe_sample_if.sink     in_smp,
  iwfe_feature_if.source  out_feat
);

  localparam int AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int LW   = $clog2(WINDOW) + 1;
  localparam int SAW  = SAMPLE_W + LW;
  localparam int QAW  = 2 * SAMPLE_W - 2 + LW;
  localparam int MSW  = SAMPLE_W + LW;
  localparam int MQW  = 2 * SAMPLE_W + LW;
  localparam int UW   = 2 * SAMPLE_W + 2 * LW;
  localparam int MBW  = SAMPLE_W + LW;
  localparam int RTW  = UW / 2;
  localparam int RMW  = RTW + 3;
  localparam int DVW  = 2 * LW;
  localparam int CW   = $clog2(UW + 1);
  localparam int GW   = 2 * SAMPLE_W;
  localparam int HALF = WINDOW / 2;

  localparam logic [DVW-1:0] WIN_D    = DVW'(WINDOW);
  localparam logic [DVW-1:0] WIN_SQ_D = DVW'(WINDOW * WINDOW);
  localparam logic [MBW-1:0] WIN_M    = MBW'(WINDOW);

  state_t state_r;
  state_t ret_r;

  logic [6*SAMPLE_W-1:0] win_mem [WINDOW];
  logic [6*SAMPLE_W-1:0] rd_data_r;

  logic [AW-1:0] wp_r;
  logic [AW-1:0] i_r;
  logic [LW-1:0] fill_r;
  logic [LW-1:0] since_r;
  logic [2:0]    k_r;
  logic [IDX_W-1:0] f_r;

  logic signed [SAW-1:0] ax_sum_r [6];
  logic [QAW-1:0]        ax_sq_r  [6];
  logic [MSW-1:0]        a_sum_r;
  logic [MSW-1:0]        g_sum_r;
  logic [MQW-1:0]        a_sq_r;
  logic [MQW-1:0]        g_sq_r;
  logic [SAMPLE_W-1:0]   a_max_r;
  logic [SAMPLE_W-1:0]   a_min_r;
  logic [SAMPLE_W-1:0]   g_max_r;
  logic [GW-1:0]         grp_r;

  logic [UW-1:0]  mul_a_r;
  logic [MBW-1:0] mul_b_r;
  logic [UW-1:0]  prod_r;
  logic [CW-1:0]  cnt_r;
  logic [UW-1:0]  sq_v_r;
  logic [RMW-1:0] rem_r;
  logic [RTW-1:0] root_r;
  logic [UW-1:0]  dv_q_r;
  logic [DVW:0]   dv_rem_r;
  logic [DVW-1:0] dv_d_r;
  logic [UW-1:0]  ta_r;
  logic [FEAT_W-1:0] res_r;

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [FEAT_W-1:0] out_val_r;
  logic              out_last_r;

  logic in_acc;
  logic out_acc;
  logic [LW-1:0] fill_inc;
  logic [LW-1:0] since_inc;
  logic due;
  sample_t cur_ax;
  logic [SAMPLE_W-1:0] cur_abs;
  logic [SAMPLE_W-1:0] mag;
  logic [RMW-1:0] rem_sh;
  logic [RMW-1:0] trial;
  logic [DVW:0]   dv_sh;
  logic [2:0]     ax_sel;
  logic signed [SAW-1:0] ax_s;
  logic [MBW-1:0] std_abs;
  logic [UW-1:0]  std_sq;
  logic [UW-1:0]  mean_src;
  logic [GW-1:0]  grp_sum;

  assign in_acc        = in_smp.valid && in_smp.ready;
  assign out_acc       = out_feat.valid && out_feat.ready;
  assign in_smp.ready  = (state_r == S_IDLE);
  assign out_feat.valid         = out_valid_r;
  assign out_feat.feature_index = out_idx_r;
  assign out_feat.feature_value = out_val_r;
  assign out_feat.last_feature  = out_last_r;

  assign fill_inc  = (fill_r == LW'(WINDOW)) ? fill_r : fill_r + 1'b1;
  assign since_inc = (since_r == LW'(WINDOW)) ? since_r : since_r + 1'b1;
  assign due       = (fill_inc == LW'(WINDOW)) && (since_inc >= LW'(HALF));

  assign cur_ax  = sample_t'(rd_data_r[k_r*SAMPLE_W +: SAMPLE_W]);
  assign cur_abs = cur_ax[SAMPLE_W-1] ? SAMPLE_W'(-cur_ax) : SAMPLE_W'(cur_ax);
  assign mag     = root_r[SAMPLE_W-1:0];
  assign grp_sum = grp_r + GW'(prod_r);

  assign rem_sh = {rem_r[RMW-3:0], sq_v_r[UW-1 -: 2]};
  assign trial  = RMW'({root_r, 2'b01});
  assign dv_sh  = {dv_rem_r[DVW-1:0], dv_q_r[UW-1]};

  assign ax_sel = (f_r >= F_AX_STD && f_r <= F_RZ_STD) ? 3'(f_r - F_AX_STD) : 3'd0;
  assign ax_s   = ax_sum_r[ax_sel];

  always_comb begin
    case (f_r)
      F_A_STD: begin
        std_abs = MBW'(a_sum_r);
        std_sq  = UW'(a_sq_r);
      end
      F_G_STD: begin
        std_abs = MBW'(g_sum_r);
        std_sq  = UW'(g_sq_r);
      end
      default: begin
        std_abs = ax_s[SAW-1] ? MBW'(-ax_s) : MBW'(ax_s);
        std_sq  = UW'(ax_sq_r[ax_sel]);
      end
    endcase
  end

  always_comb begin
    case (f_r)
      F_A_MEAN:   mean_src = UW'(a_sum_r);
      F_G_MEAN:   mean_src = UW'(g_sum_r);
      F_A_ENERGY: mean_src = UW'(a_sq_r);
      default:    mean_src = UW'(g_sq_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_mem[wp_r] <= {in_smp.rate_z, in_smp.rate_y, in_smp.rate_x,
                        in_smp.accel_z, in_smp.accel_y, in_smp.accel_x};
    end
    rd_data_r <= win_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      since_r     <= '0;
      i_r         <= '0;
      k_r         <= '0;
      f_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            wp_r   <= (wp_r == AW'(WINDOW - 1)) ? '0 : wp_r + 1'b1;
            fill_r <= fill_inc;
            if (due) begin
              since_r <= '0;
              i_r     <= '0;
              grp_r   <= '0;
              a_sum_r <= '0;
              g_sum_r <= '0;
              a_sq_r  <= '0;
              g_sq_r  <= '0;
              for (int n = 0; n < 6; n++) begin
                ax_sum_r[n] <= '0;
                ax_sq_r[n]  <= '0;
              end
              state_r <= S_READ;
            end else begin
              since_r <= since_inc;
            end
          end
        end
        S_READ: begin
          k_r     <= '0;
          state_r <= S_AXIS;
        end
        S_AXIS: begin
          ax_sum_r[k_r] <= ax_sum_r[k_r] + SAW'(cur_ax);
          mul_a_r <= UW'(cur_abs);
          mul_b_r <= MBW'(cur_abs);
          prod_r  <= '0;
          cnt_r   <= '0;
          ret_r   <= S_AXACC;
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (mul_b_r[0]) prod_r <= prod_r + mul_a_r;
          mul_a_r <= mul_a_r << 1;
          mul_b_r <= mul_b_r >> 1;
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == CW'(MBW - 1)) state_r <= ret_r;
        end
        S_AXACC: begin
          ax_sq_r[k_r] <= ax_sq_r[k_r] + QAW'(prod_r);
          if (k_r == 3'd2 || k_r == 3'd5) begin
            sq_v_r  <= UW'(grp_sum);
            grp_r   <= '0;
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= '0;
            ret_r   <= S_MAGSQ;
            state_r <= S_SQRT;
          end else begin
            grp_r   <= grp_sum;
            k_r     <= k_r + 1'b1;
            state_r <= S_AXIS;
          end
        end
        S_SQRT: begin
          sq_v_r <= sq_v_r << 2;
          if (rem_sh >= trial) begin
            rem_r  <= rem_sh - trial;
            root_r <= {root_r[RTW-2:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[RTW-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(RTW - 1)) state_r <= ret_r;
        end
        S_MAGSQ: begin
          if (k_r == 3'd2) begin
            a_sum_r <= a_sum_r + MSW'(mag);
            if (i_r == '0 || mag > a_max_r) a_max_r <= mag;
            if (i_r == '0 || mag < a_min_r) a_min_r <= mag;
          end else begin
            g_sum_r <= g_sum_r + MSW'(mag);
            if (i_r == '0 || mag > g_max_r) g_max_r <= mag;
          end
          mul_a_r <= UW'(mag);
          mul_b_r <= MBW'(mag);
          prod_r  <= '0;
          cnt_r   <= '0;
          ret_r   <= S_MAGACC;
          state_r <= S_MUL;
        end
        S_MAGACC: begin
          if (k_r == 3'd2) begin
            a_sq_r  <= a_sq_r + MQW'(prod_r);
            k_r     <= 3'd3;
            state_r <= S_AXIS;
          end else begin
            g_sq_r <= g_sq_r + MQW'(prod_r);
            if (i_r == AW'(WINDOW - 1)) begin
              f_r     <= '0;
              state_r <= S_FEAT;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_READ;
            end
          end
        end
        S_FEAT: begin
          case (f_r)
            F_A_MAX: begin
              res_r   <= FEAT_W'(a_max_r);
              state_r <= S_EMIT;
            end
            F_A_MIN: begin
              res_r   <= FEAT_W'(a_min_r);
              state_r <= S_EMIT;
            end
            F_A_P2P: begin
              res_r   <= FEAT_W'(a_max_r - a_min_r);
              state_r <= S_EMIT;
            end
            F_G_MAX: begin
              res_r   <= FEAT_W'(g_max_r);
              state_r <= S_EMIT;
            end
            F_A_MEAN, F_G_MEAN, F_A_ENERGY, F_G_ENERGY: begin
              dv_q_r   <= mean_src;
              dv_rem_r <= '0;
              dv_d_r   <= WIN_D;
              cnt_r    <= '0;
              ret_r    <= S_DVDONE;
              state_r  <= S_DIV;
            end
            default: begin
              mul_a_r <= std_sq;
              mul_b_r <= WIN_M;
              prod_r  <= '0;
              cnt_r   <= '0;
              ret_r   <= S_STDB;
              state_r <= S_MUL;
            end
          endcase
        end
        S_STDB: begin
          ta_r    <= prod_r;
          mul_a_r <= UW'(std_abs);
          mul_b_r <= std_abs;
          prod_r  <= '0;
          cnt_r   <= '0;
          ret_r   <= S_STDC;
          state_r <= S_MUL;
        end
        S_STDC: begin
          if (ta_r <= prod_r) begin
            res_r   <= '0;
            state_r <= S_EMIT;
          end else begin
            dv_q_r   <= ta_r - prod_r;
            dv_rem_r <= '0;
            dv_d_r   <= WIN_SQ_D;
            cnt_r    <= '0;
            ret_r    <= S_STDSQ;
            state_r  <= S_DIV;
          end
        end
        S_DIV: begin
          if (dv_sh >= {1'b0, dv_d_r}) begin
            dv_rem_r <= dv_sh - {1'b0, dv_d_r};
            dv_q_r   <= {dv_q_r[UW-2:0], 1'b1};
          end else begin
            dv_rem_r <= dv_sh;
            dv_q_r   <= {dv_q_r[UW-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(UW - 1)) state_r <= ret_r;
        end
        S_DVDONE: begin
          res_r   <= dv_q_r[FEAT_W-1:0];
          state_r <= S_EMIT;
        end
        S_STDSQ: begin
          sq_v_r  <= dv_q_r;
          rem_r   <= '0;
          root_r  <= '0;
          cnt_r   <= '0;
          ret_r   <= S_SQDONE;
          state_r <= S_SQRT;
        end
        S_SQDONE: begin
          res_r   <= FEAT_W'(root_r);
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          out_valid_r <= 1'b1;
          out_idx_r   <= f_r;
          out_val_r   <= res_r;
          out_last_r  <= (f_r == F_G_ENERGY);
          state_r     <= S_WAIT;
        end
        S_WAIT: begin
          if (out_acc) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              f_r     <= f_r + 1'b1;
              state_r <= S_FEAT;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_WAIT))
    else $error("result valid outside of delivery");

  a_no_input_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_smp.ready |-> !out_valid_r)
    else $error("sample taken while a feature is pending");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LW'(WINDOW) && since_r <= LW'(WINDOW))
    else $error("window counters out of range");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_r) |=> in_smp.ready)
    else $error("no return to idle after the last feature");
`endif

endmodule
`default_nettype wire
